// ----- sv/positional_sequence_store_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the positional sequence store unit
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_SEQUENCE_STORE_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PSS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication
`define PSS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// ----- sv/pss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg
// Constants and types shared by the positional sequence store unit.
// ----------------------------------------------------------------------------
package pss_pkg;
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(CAPACITY);
    localparam int CW         = $clog2(CAPACITY + 1);

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_POS   = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [2:0] CMD_DEL_POS   = 3'd5;
    localparam logic [2:0] CMD_READ      = 3'd6;
    localparam logic [2:0] CMD_UNUSED    = 3'd7;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ELEMENT = 2'd3;

    typedef logic [AW-1:0]         t_addr;
    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_data wdata;
        t_addr raddr;
    } t_mem_req;
endpackage
`default_nettype wire

// ----- sv/pss_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pss_ram
// Element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pss_ram import pss_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_data         o_rdata
);
    t_data r_mem [CAPACITY];
    t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- sv/pss_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pss_ctrl
// Command sequencer: decodes, shifts entries one per cycle, streams readout.
// ----------------------------------------------------------------------------
module pss_ctrl import pss_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_item_value,
    input  wire logic [7:0]  i_position,
    input  wire t_data       i_rdata,
    output t_mem_req         o_req,
    output logic             o_busy,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [31:0]      o_element_value,
    output logic [6:0]       o_element_index,
    output logic [6:0]       o_element_count,
    output logic             o_last_of_run
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_DEL  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;       // current slot being moved/read
    logic [CW-1:0] r_tgt, n_tgt;       // target slot (0-based)
    t_data       r_val, n_val;
    logic        r_pend, n_pend;       // read issued last cycle
    logic [CW-1:0] r_pslot, n_pslot;
    logic        r_ov, n_ov;
    logic [1:0]  r_st, n_st;
    logic [6:0]  r_ei, n_ei;
    logic        r_lr, n_lr;

    logic [8:0]  w_pos;
    t_mem_req    w_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
        r_ptr   <= n_ptr;
        r_tgt   <= n_tgt;
        r_val   <= n_val;
        r_pslot <= n_pslot;
        r_st    <= n_st;
        r_ei    <= n_ei;
        r_lr    <= n_lr;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_tgt   = r_tgt;
        n_val   = r_val;
        n_pend  = 1'b0;
        n_pslot = r_pslot;
        n_ov    = 1'b0;
        n_st    = r_st;
        n_ei    = '0;
        n_lr    = 1'b1;
        w_req   = '0;
        w_pos   = 9'd0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val = i_item_value[DATA_WIDTH-1:0];
                    case (i_cmd)
                        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
                            if (i_cmd == CMD_INS_FRONT) w_pos = 9'd1;
                            else if (i_cmd == CMD_INS_BACK) w_pos = 9'(r_count) + 9'd1;
                            else w_pos = {1'b0, i_position};
                            if (w_pos < 9'd1 || w_pos > 9'(r_count) + 9'd1) begin
                                n_st = ST_IGNORED; n_state = S_FIN;
                            end else if (r_count >= CW'(CAPACITY)) begin
                                n_st = ST_FULL; n_state = S_FIN;
                            end else begin
                                n_tgt = CW'(w_pos - 9'd1);
                                n_ptr = r_count;
                                n_st = ST_DONE; n_state = S_INS;
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
                            if (i_cmd == CMD_DEL_FRONT) w_pos = 9'd1;
                            else if (i_cmd == CMD_DEL_BACK) w_pos = 9'(r_count);
                            else w_pos = {1'b0, i_position};
                            if (r_count == '0 || w_pos < 9'd1 || w_pos > 9'(r_count)) begin
                                n_st = ST_IGNORED; n_state = S_FIN;
                            end else begin
                                n_ptr = CW'(w_pos - 9'd1);
                                n_st = ST_DONE; n_state = S_DEL;
                            end
                        end
                        CMD_READ: begin
                            if (r_count == '0) begin
                                n_st = ST_IGNORED; n_state = S_FIN;
                            end else begin
                                n_ptr = '0; n_state = S_RD;
                            end
                        end
                        default: begin
                            n_st = ST_IGNORED; n_state = S_FIN;
                        end
                    endcase
                end
            end
            // shift up: read ptr-1, write ptr on next cycle
            S_INS: begin
                if (r_pend) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_pslot[AW-1:0];
                    w_req.wdata = i_rdata;
                end
                if (r_ptr == r_tgt) begin
                    if (!r_pend) begin
                        w_req.we    = 1'b1;
                        w_req.waddr = r_tgt[AW-1:0];
                        w_req.wdata = r_val;
                        n_count = r_count + 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_pend = 1'b0;
                    end
                end else begin
                    w_req.raddr = AW'(r_ptr - 1'b1);
                    n_pend  = 1'b1;
                    n_pslot = r_ptr;
                    n_ptr   = r_ptr - 1'b1;
                end
            end
            // shift down: read ptr+1, write ptr on next cycle
            S_DEL: begin
                if (r_pend) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_pslot[AW-1:0];
                    w_req.wdata = i_rdata;
                end
                if (r_ptr + 1'b1 >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_req.raddr = AW'(r_ptr + 1'b1);
                    n_pend  = 1'b1;
                    n_pslot = r_ptr;
                    n_ptr   = r_ptr + 1'b1;
                end
            end
            S_RD: begin
                if (r_ptr < r_count) begin
                    w_req.raddr = r_ptr[AW-1:0];
                    n_ptr = r_ptr + 1'b1;
                    n_ov  = 1'b1;
                    n_st  = ST_ELEMENT;
                    n_ei  = 7'(r_ptr + 1'b1);
                    n_lr  = (r_ptr + 1'b1 == r_count);
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                n_ov    = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_req           = w_req;
    assign o_busy          = (r_state != S_IDLE) || r_ov;
    assign o_valid         = r_ov;
    assign o_status        = r_st;
    assign o_element_value = (r_st == ST_ELEMENT) ? 32'($signed(i_rdata)) : 32'd0;
    assign o_element_index = r_ei;
    assign o_element_count = 7'(r_count);
    assign o_last_of_run   = r_lr;
endmodule
`default_nettype wire

// ----- sv/positional_sequence_store_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// positional_sequence_store_unit
// Ordered sequence of up to 64 signed words, kept packed in one RAM.
// ----------------------------------------------------------------------------
// Usage: drive i_cmd, i_item_value, i_position and raise start while
// busy is low; the word is taken at that edge. Results come one per cycle,
// each marked by o_valid for a single cycle; o_last_of_run flags the final
// one. The receiver cannot stall; every result must be captured when shown.
// Steps from the accepting edge to the last result: rejected and unknown
// commands go straight to their result. Delete at 1-based position p
// shifts the entries after p down, one RAM read/write per shifted entry.
// Insert at p below the back shifts the entries from p up, one RAM
// read/write per shifted entry, then writes the new word; append writes it
// at once. Readout reads each element through the single RAM read port,
// one per cycle. Busy stays high until the last result has been shown.
// Reset (synchronous, active low) empties the store; RAM contents are not
// cleared, only the count, and stale entries are never read.
// ----------------------------------------------------------------------------
`include "positional_sequence_store_unit_defines.svh"
module positional_sequence_store_unit import pss_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_item_value,
    input  wire logic [7:0]  i_position,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [31:0]      o_element_value,
    output logic [6:0]       o_element_index,
    output logic [6:0]       o_element_count,
    output logic             o_last_of_run
);
    t_mem_req w_req;
    t_data    w_rdata;
    logic     w_elem_shown;
    logic     w_idx_ok;

    pss_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    pss_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start && !busy),
        .i_cmd           (i_cmd),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .i_rdata         (w_rdata),
        .o_req           (w_req),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_element_value (o_element_value),
        .o_element_index (o_element_index),
        .o_element_count (o_element_count),
        .o_last_of_run   (o_last_of_run)
    );

    assign w_elem_shown = o_valid && (o_status == ST_ELEMENT);
    assign w_idx_ok     = (o_element_index >= 7'd1) && (o_element_index <= o_element_count);

    `PSS_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, o_element_count <= 7'(CAPACITY))
    `PSS_ASSERT_IMP(a_idx_in_count, i_clk, i_rst_n, w_elem_shown, w_idx_ok)
    `PSS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
endmodule
`default_nettype wire
